// File: design/iirl_pkg.sv
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and constants of the indexed insert/remove list
// Operation codes, status codes, word widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package iirl_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 7;
    localparam int FUNC_W = 4;
    localparam int STAT_W = 2;
    localparam int IN_W = 48;
    localparam int OUT_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD_AT       = 4'd0,
        F_ADD_FIRST    = 4'd1,
        F_ADD_LAST     = 4'd2,
        F_REMOVE_AT    = 4'd3,
        F_REMOVE_FIRST = 4'd4,
        F_REMOVE_LAST  = 4'd5,
        F_GET_AT       = 4'd6,
        F_GET_FIRST    = 4'd7,
        F_GET_LAST     = 4'd8,
        F_CLEAR        = 4'd9
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // Broadcast to every cell: shift direction, index and word to insert
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [CNT_W-1:0] idx;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

    localparam logic [VAL_W-1:0] NO_VALUE = '1;

endpackage

// File: design/iirl_cell.sv
// ----------------------------------------------------------------------------
// iirl_cell: one entry of the list
// Holds one word; on insert takes its left neighbor above the index or the new word at it,
// on remove its right neighbor from the index on, and drives its word onto the read tree when addressed.
// ----------------------------------------------------------------------------
module iirl_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  iirl_pkg::t_cell_ctl       i_ctl,
    input  logic [iirl_pkg::CNT_W-1:0] i_rd_idx,
    input  logic [iirl_pkg::VAL_W-1:0] i_left,
    input  logic [iirl_pkg::VAL_W-1:0] i_right,
    output logic [iirl_pkg::VAL_W-1:0] o_data,
    output logic [iirl_pkg::VAL_W-1:0] o_leaf
);
    import iirl_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    // Pick the next word: shift up, load, shift down or hold
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && (IDX > int'(i_ctl.idx))) begin
            n_data = i_left;
        end else if (i_ctl.ins && (IDX == int'(i_ctl.idx))) begin
            n_data = i_ctl.value;
        end else if (i_ctl.rem && (IDX >= int'(i_ctl.idx))) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Drive the read tree only when addressed
    assign o_data = r_data;
    assign o_leaf = (int'(i_rd_idx) == IDX) ? r_data : '0;

endmodule

// File: design/iirl_rdtree.sv
// ----------------------------------------------------------------------------
// iirl_rdtree: read collection tree
// ORs the masked cell words in registered groups of eight, then ORs the
// group registers into the selected word.
// ----------------------------------------------------------------------------
module iirl_rdtree #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic [iirl_pkg::VAL_W-1:0] i_leaf [DEPTH],
    output logic [iirl_pkg::VAL_W-1:0] o_word
);
    import iirl_pkg::*;

    localparam int GRP = 8;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    logic [VAL_W-1:0] r_grp [NGRP];
    logic [VAL_W-1:0] n_grp [NGRP];

    // Fold each group of leaves
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DEPTH) begin
                    n_grp[g] = n_grp[g] | i_leaf[g * GRP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp[g] <= n_grp[g];
        end
    end

    // Fold the group registers
    always_comb begin
        o_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule

// File: design/indexed_insert_remove_list_core.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_core: ordered list of words
// Insert, remove and read at an index, plus clear, over a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one command word per item: func, position and
//   new_value. The master stream returns one result word per command: status,
//   read_value, entry_count, is_full and is_empty.
//   Inserts and removes shift the cells from the command's index on in the cycle the command
//   is accepted. Reads are collected through a two-level OR tree whose first
//   level is registered, so a read passes the index and group registers.
//   One command is in work at a time: an item passes S_GRP and S_OUT,
//   and the next one is taken as soon as the core is back in idle.
//   A finished result sits in the output register; the core accepts and works
//   on the next command meanwhile and only waits, holding that result, when
//   the receiver stalls with the output register still full.
//   Reset empties the list and sets capacity_limit to 64; entry words are not
//   cleared and are never read before they are written.
//   The user writes capacity_limit over APB at address 0 only while idle; the core does not enforce it.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_core #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // tdata: [3:0] func, [10:4] position, [42:11] new_value, [47:43] zero
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [iirl_pkg::IN_W-1:0]  s_tdata,
    // tdata: [1:0] status, [33:2] read_value, [40:34] entry_count,
    //        [41] is_full, [42] is_empty, [47:43] zero
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [iirl_pkg::OUT_W-1:0] m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import iirl_pkg::*;

    localparam int DCAP = (DEPTH > 127) ? 127 : DEPTH;
    localparam logic [2:0] ADDR_CAP = 3'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GRP,
        S_OUT
    } t_state;

    t_state           r_st, n_st;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap, n_cap;
    logic [STAT_W-1:0] r_status, n_status;
    logic             r_rd_ok, n_rd_ok;
    logic             r_full, n_full;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_m_valid, n_m_valid;
    logic [OUT_W-1:0] r_m_data, n_m_data;

    logic             accept;
    logic             load;
    logic             cfg_wr;
    t_func            func;
    logic [CNT_W-1:0] pos;
    logic [VAL_W-1:0] new_value;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] op_idx;
    t_status          st;
    logic             ins, rem, rd_ok, clr;
    logic [CNT_W-1:0] cnt_next;
    logic [VAL_W-1:0] tree_word;
    logic [VAL_W-1:0] rd_value;
    t_cell_ctl        cell_ctl;

    logic [VAL_W-1:0] cell_data [DEPTH];
    logic [VAL_W-1:0] cell_leaf [DEPTH];

    // Unpack the command word
    assign func      = t_func'(s_tdata[3:0]);
    assign pos       = s_tdata[10:4];
    assign new_value = s_tdata[42:11];

    assign s_tready = (r_st == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (r_st == S_OUT) && (!r_m_valid || m_tready);
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_CAP);

    assign cap_eff = (int'(r_cap) > DCAP) ? CNT_W'(DCAP) : r_cap;

    // Decode the command against the current count
    always_comb begin
        op_idx = pos;
        st     = ST_INVALID;
        ins    = 1'b0;
        rem    = 1'b0;
        rd_ok  = 1'b0;
        clr    = 1'b0;
        case (func)
            F_ADD_AT, F_ADD_FIRST, F_ADD_LAST: begin
                if (func == F_ADD_FIRST) begin
                    op_idx = '0;
                end else if (func == F_ADD_LAST) begin
                    op_idx = r_count;
                end
                if (op_idx > r_count) begin
                    st = ST_INVALID;
                end else if (r_count >= cap_eff) begin
                    st = ST_FULL;
                end else begin
                    st  = ST_OK;
                    ins = 1'b1;
                end
            end
            F_REMOVE_AT, F_REMOVE_FIRST: begin
                if (func == F_REMOVE_FIRST) begin
                    op_idx = '0;
                end
                if ((r_count == '0) || (op_idx >= r_count)) begin
                    st = ST_INVALID;
                end else begin
                    st  = ST_OK;
                    rem = 1'b1;
                end
            end
            F_REMOVE_LAST: begin
                op_idx = r_count - 1'b1;
                if (r_count == '0) begin
                    st = ST_EMPTY;
                end else begin
                    st  = ST_OK;
                    rem = 1'b1;
                end
            end
            F_GET_AT, F_GET_FIRST, F_GET_LAST: begin
                if (func == F_GET_FIRST) begin
                    op_idx = '0;
                end else if (func == F_GET_LAST) begin
                    op_idx = r_count - 1'b1;
                end
                if ((r_count == '0) || (op_idx >= r_count)) begin
                    st = ST_INVALID;
                end else begin
                    st    = ST_OK;
                    rd_ok = 1'b1;
                end
            end
            F_CLEAR: begin
                st  = ST_OK;
                clr = 1'b1;
            end
            default: begin
                st = ST_INVALID;
            end
        endcase

        if (ins) begin
            cnt_next = r_count + 1'b1;
        end else if (rem) begin
            cnt_next = r_count - 1'b1;
        end else if (clr) begin
            cnt_next = '0;
        end else begin
            cnt_next = r_count;
        end
    end

    // Broadcast the shift only on the accepting edge
    always_comb begin
        cell_ctl.ins   = accept && ins;
        cell_ctl.rem   = accept && rem;
        cell_ctl.idx   = op_idx;
        cell_ctl.value = new_value;
    end

    // Row of cells, each linked to its neighbors
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [VAL_W-1:0] left_w;
        logic [VAL_W-1:0] right_w;
        if (k == 0) begin : g_head
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_tail
            assign right_w = cell_data[k];
        end else begin : g_mid_r
            assign right_w = cell_data[k+1];
        end
        iirl_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_rd_idx (r_rd_idx),
            .i_left   (left_w),
            .i_right  (right_w),
            .o_data   (cell_data[k]),
            .o_leaf   (cell_leaf[k])
        );
    end

    iirl_rdtree #(
        .DEPTH (DEPTH)
    ) u_rdtree (
        .i_clk  (i_clk),
        .i_leaf (cell_leaf),
        .o_word (tree_word)
    );

    assign rd_value = r_rd_ok ? tree_word : NO_VALUE;

    // Next state of the sequencer, counters and output register
    always_comb begin
        n_st      = r_st;
        n_count   = r_count;
        n_cap     = r_cap;
        n_status  = r_status;
        n_rd_ok   = r_rd_ok;
        n_full    = r_full;
        n_rd_idx  = r_rd_idx;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        if (cfg_wr) begin
            n_cap = pwdata[CNT_W-1:0];
        end

        if (m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_st)
            S_IDLE: begin
                if (accept) begin
                    n_count  = cnt_next;
                    n_status = st;
                    n_rd_ok  = rd_ok;
                    n_full   = (cnt_next >= cap_eff);
                    n_rd_idx = op_idx;
                    n_st     = S_GRP;
                end
            end
            S_GRP: begin
                n_st = S_OUT;
            end
            S_OUT: begin
                if (load) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {5'b0, (r_count == '0), r_full, r_count, rd_value,
                                 r_status};
                    n_st      = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_count   <= '0;
            r_cap     <= CNT_W'(64);
            r_m_valid <= 1'b0;
        end else begin
            r_st      <= n_st;
            r_count   <= n_count;
            r_cap     <= n_cap;
            r_m_valid <= n_m_valid;
        end
        r_status <= n_status;
        r_rd_ok  <= n_rd_ok;
        r_full   <= n_full;
        r_rd_idx <= n_rd_idx;
        r_m_data <= n_m_data;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_CAP) ? {{(32-CNT_W){1'b0}}, r_cap} : '0;

`ifndef NO_ASSERTIONS
    // Count never leaves the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= DEPTH)
        else $error("entry count beyond depth");

    // Only one command in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_tready)
        else $error("command taken while another is in work");

    // Count moves only on an accepted command
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("count changed without a command");

    // A failed command never carries a read word
    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[33:2] == NO_VALUE))
        else $error("failed command returned a value");

    // Empty flag agrees with the reported count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[42] == (m_tdata[40:34] == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

// File: tb/sv/tb_indexed_insert_remove_list_core.sv
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_list_core: self-checking bench of the list core
// Drives list commands over the slave stream with bursty gaps and takes the
// results on the master stream under a changing stall pattern. A local
// list predictor computes every result as its command is accepted. A
// scoreboard compares the results field by field, in order. The capacity
// register is swept over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_list_core;

    import iirl_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTED = 20;
    localparam logic [2:0] REG_CAPACITY_LIMIT = 3'd0;
    // Codes beyond the last operation; the core must reject them
    localparam logic [FUNC_W-1:0] F_UNUSED_FIRST = 4'd10;
    localparam logic [FUNC_W-1:0] F_UNUSED_LAST = 4'd15;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] entry_count;
        logic             is_full;
        logic             is_empty;
    } t_list_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_LONG_STALLS
    } t_rx_mode;

    // DUT ports, all driven from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predicted list contents and configuration
    logic [VAL_W-1:0]  list_mem [LIST_DEPTH];
    int                list_len = 0;
    logic [CNT_W-1:0]  cap_reg = 7'd64;

    t_list_result      pending_results [$];
    int                mismatch_cnt = 0;
    int                cycle_cnt = 0;
    int                burst_left = 0;
    int                n_cmds = 0;
    int                n_full_hits = 0;
    int                n_reads_ok = 0;
    int                n_cap_writes = 0;
    int                max_len = 0;

    // Receiver stall pattern
    t_rx_mode          rx_mode = RX_ALWAYS;
    logic [5:0]        rx_phase = '0;
    int                stall_left = 0;

    indexed_insert_remove_list_core #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------
    function automatic int effective_cap();
        return (cap_reg > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
    endfunction

    // Index check first, then capacity; shift the tail up by one
    function automatic t_status list_insert(int idx, logic [VAL_W-1:0] word);
        if (idx > list_len)
            return ST_INVALID;
        if (list_len >= effective_cap() || list_len >= LIST_DEPTH)
            return ST_FULL;
        for (int i = list_len; i > idx; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[idx] = word;
        list_len++;
        return ST_OK;
    endfunction

    // Shift the tail down by one over the removed entry
    function automatic t_status list_remove(int idx);
        if (list_len == 0 || idx >= list_len)
            return ST_INVALID;
        for (int i = idx; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i+1];
        list_len--;
        return ST_OK;
    endfunction

    function automatic t_status list_read(int idx, output logic [VAL_W-1:0] word);
        if (idx >= list_len || idx >= LIST_DEPTH) begin
            word = NO_VALUE;
            return ST_INVALID;
        end
        word = list_mem[idx];
        return ST_OK;
    endfunction

    function automatic t_list_result apply_list_op(logic [FUNC_W-1:0] f,
                                                   logic [CNT_W-1:0] pos,
                                                   logic [VAL_W-1:0] word);
        t_list_result r;
        r.read_value = NO_VALUE;
        case (f)
            F_ADD_AT:       r.status = list_insert(int'(pos), word);
            F_ADD_FIRST:    r.status = list_insert(0, word);
            F_ADD_LAST:     r.status = list_insert(list_len, word);
            F_REMOVE_AT:    r.status = list_remove(int'(pos));
            F_REMOVE_FIRST: r.status = list_remove(0);
            // Remove last on an empty list reports empty, not invalid
            F_REMOVE_LAST: begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.status = list_remove(list_len - 1);
            end
            F_GET_AT:       r.status = list_read(int'(pos), r.read_value);
            F_GET_FIRST:    r.status = list_read(0, r.read_value);
            F_GET_LAST: begin
                if (list_len == 0)
                    r.status = ST_INVALID;
                else
                    r.status = list_read(list_len - 1, r.read_value);
            end
            F_CLEAR: begin
                list_len = 0;
                r.status = ST_OK;
            end
            default:        r.status = ST_INVALID;
        endcase
        r.entry_count = list_len[CNT_W-1:0];
        r.is_full = (list_len >= effective_cap());
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : score_result
        t_list_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(m_tdata[1:0]), 32'(want.status));
                check_field("read_value", m_tdata[33:2], want.read_value);
                check_field("entry_count", 32'(m_tdata[40:34]), 32'(want.entry_count));
                check_field("is_full", 32'(m_tdata[41]), 32'(want.is_full));
                check_field("is_empty", 32'(m_tdata[42]), 32'(want.is_empty));
            end
        end
    end

    // Receiver: change the stall pattern each time rx_phase wraps to zero
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 6'd1;
        if (rx_phase == '0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS:      m_tready <= 1'b1;
            RX_COIN:        m_tready <= 1'($urandom_range(0, 1));
            RX_ONE_IN_FOUR: m_tready <= (rx_phase[1:0] == 2'b00);
            default: begin
                if (stall_left != 0) begin
                    m_tready <= 1'b0;
                    stall_left <= stall_left - 1;
                end else if ($urandom_range(0, 7) == 0) begin
                    m_tready <= 1'b0;
                    stall_left <= $urandom_range(4, 15);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a valid index for the current length, sometimes anything
    function automatic logic [CNT_W-1:0] pick_position(logic [FUNC_W-1:0] f);
        if ($urandom_range(0, 3) != 0) begin
            if (f == F_ADD_AT)
                return CNT_W'($urandom_range(0, list_len));
            if ((f == F_REMOVE_AT || f == F_GET_AT) && list_len > 0)
                return CNT_W'($urandom_range(0, list_len - 1));
        end
        return CNT_W'($urandom_range(0, 127));
    endfunction

    // Send one command word in bursts; predict its result on acceptance
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [CNT_W-1:0] pos,
                            input logic [VAL_W-1:0] word);
        int gap;
        t_list_result r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, word, pos, f};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        burst_left--;
        r = apply_list_op(f, pos, word);
        pending_results.push_back(r);
        n_cmds++;
        if (r.status == ST_FULL)
            n_full_hits++;
        if (r.status == ST_OK && (f == F_GET_AT || f == F_GET_FIRST || f == F_GET_LAST))
            n_reads_ok++;
        if (list_len > max_len)
            max_len = list_len;
    endtask

    // Drop valid, drain every pending result, then let the core settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // One APB transfer: setup, access, then idle
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        logic [31:0] rd;
        apb_access(1'b1, REG_CAPACITY_LIMIT, {25'b0, cap}, rd);
        cap_reg = cap;
        n_cap_writes++;
        apb_access(1'b0, REG_CAPACITY_LIMIT, 32'h0, rd);
        check_field("capacity_limit readback", rd, {25'b0, cap});
    endtask

    // Random mix; ins_pct steers inserts against removes
    task automatic run_random_mix(input int n, input int ins_pct);
        logic [FUNC_W-1:0] f;
        int rr;
        for (int i = 0; i < n; i++) begin
            rr = $urandom_range(0, 99);
            if (rr < 1)
                f = F_CLEAR;
            else if (rr < 4)
                f = FUNC_W'($urandom_range(F_UNUSED_FIRST, F_UNUSED_LAST));
            else if (rr < 24)
                f = FUNC_W'(F_GET_AT + $urandom_range(0, 2));
            else if ($urandom_range(0, 99) < ins_pct)
                f = FUNC_W'(F_ADD_AT + $urandom_range(0, 2));
            else
                f = FUNC_W'(F_REMOVE_AT + $urandom_range(0, 2));
            send_cmd(f, pick_position(f), rand_word());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Empty-list errors, edge words, bad indexes, unknown codes, clear
    task automatic test_directed();
        send_cmd(F_GET_FIRST, 7'd0, 32'h0);
        send_cmd(F_GET_LAST, 7'd0, 32'h0);
        send_cmd(F_REMOVE_LAST, 7'd0, 32'h0);
        send_cmd(F_REMOVE_AT, 7'd0, 32'h0);
        send_cmd(F_REMOVE_FIRST, 7'd0, 32'h0);
        send_cmd(F_ADD_AT, 7'd1, 32'h1234_5678);
        send_cmd(F_ADD_AT, 7'd0, 32'h8000_0000);
        send_cmd(F_ADD_FIRST, 7'd127, 32'h7FFF_FFFF);
        send_cmd(F_ADD_LAST, 7'd64, 32'hFFFF_FFFF);
        send_cmd(F_ADD_LAST, 7'd0, 32'h0000_0000);
        send_cmd(F_ADD_AT, 7'd2, 32'h5555_5555);
        send_cmd(F_ADD_AT, 7'd127, 32'hAAAA_AAAA);
        for (int i = 0; i < 6; i++)
            send_cmd(F_GET_AT, i[CNT_W-1:0], 32'h0);
        send_cmd(F_GET_AT, 7'd127, 32'h0);
        send_cmd(F_REMOVE_AT, 7'd2, 32'h0);
        send_cmd(F_REMOVE_FIRST, 7'd0, 32'h0);
        send_cmd(F_REMOVE_LAST, 7'd0, 32'h0);
        send_cmd(F_UNUSED_FIRST, 7'd0, 32'h0);
        send_cmd(F_UNUSED_LAST, 7'd127, 32'hFFFF_FFFF);
        send_cmd(F_CLEAR, 7'd0, 32'h0);
        send_cmd(F_GET_FIRST, 7'd0, 32'h0);
        wait_idle();
    endtask

    // Fill to the full depth, read every slot, empty it again
    task automatic test_fill_to_depth();
        logic [FUNC_W-1:0] f;
        set_capacity(7'd64);
        for (int i = 0; i < LIST_DEPTH + 4; i++) begin
            f = FUNC_W'(F_ADD_AT + $urandom_range(0, 2));
            send_cmd(f, pick_position(f), rand_word());
        end
        for (int i = 0; i < LIST_DEPTH + 2; i++)
            send_cmd(F_GET_AT, i[CNT_W-1:0], $urandom);
        send_cmd(F_GET_FIRST, 7'd0, 32'h0);
        send_cmd(F_GET_LAST, 7'd0, 32'h0);
        for (int i = 0; i < LIST_DEPTH + 6; i++) begin
            f = FUNC_W'(F_REMOVE_AT + $urandom_range(0, 2));
            send_cmd(f, pick_position(f), rand_word());
        end
        wait_idle();
    endtask

    // Smallest, zero, saturating and middle capacities
    task automatic test_capacity_sweep();
        logic [CNT_W-1:0] caps [6];
        caps = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'($urandom_range(3, 63))};
        foreach (caps[k]) begin
            set_capacity(caps[k]);
            run_random_mix(100, 75);
            run_random_mix(50, 25);
            wait_idle();
        end
    endtask

    // Lower the capacity under the current length; entries must stay
    task automatic test_capacity_below_length();
        set_capacity(7'd64);
        send_cmd(F_CLEAR, 7'd0, 32'h0);
        for (int i = 0; i < 40; i++)
            send_cmd(F_ADD_LAST, 7'($urandom_range(0, 127)), rand_word());
        wait_idle();
        set_capacity(7'd10);
        run_random_mix(150, 50);
        wait_idle();
    endtask

    // Random capacities with balanced traffic
    task automatic test_random_mix();
        for (int k = 0; k < 4; k++) begin
            set_capacity(7'($urandom_range(1, 64)));
            run_random_mix(100, 55);
            wait_idle();
        end
    endtask

    initial begin
        foreach (list_mem[i])
            list_mem[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_to_depth();
        test_capacity_sweep();
        test_capacity_below_length();
        test_random_mix();

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("covered %0d list commands over %0d capacity settings, %0d cycles",
                 n_cmds, n_cap_writes, cycle_cnt);
        $display("full rejections %0d, good reads %0d, longest list %0d, mismatches %0d",
                 n_full_hits, n_reads_ok, max_len, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
